// ===== hw/rtl/mpc_pkg.sv =====
// Shared constants and types for the max priority collection unit.
package mpc_pkg;

   localparam int CAPACITY    = 256;
   localparam int DATA_BITS   = 32;
   localparam int PRIO_BITS   = 16;
   localparam int ID_BITS     = 8;
   localparam int IDX_BITS    = $clog2(CAPACITY);
   localparam int TOK_ID_BITS = (IDX_BITS > ID_BITS) ? IDX_BITS : ID_BITS;

   typedef logic [TOK_ID_BITS-1:0] tok_id_type;
   typedef logic [IDX_BITS:0]      cnt_type;
   typedef logic [DATA_BITS-1:0]   data_type;
   typedef logic [PRIO_BITS-1:0]   prio_type;

   localparam cnt_type  CAPACITY_CNT = cnt_type'(CAPACITY);
   localparam prio_type PRIO_MAX     = '1;

   typedef enum logic [2:0] {
      CMD_ADD      = 3'd0,
      CMD_PROMOTE  = 3'd1,
      CMD_GET_MAX  = 3'd2,
      CMD_POP_MAX  = 3'd3,
      CMD_IS_VALID = 3'd4,
      CMD_GET      = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_BAD   = 2'd2,
      STATUS_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Request token that walks the row of cells, one cell per cycle.
   // For the max commands id/data/prio hold the best entry so far and
   // flag says one was found; for promote, is-valid and get, flag is the
   // live mark of the addressed entry.
   typedef struct packed {
      logic       valid;
      cmd_type    cmd;
      tok_id_type id;
      data_type   data;
      prio_type   prio;
      logic       flag;
   } token_type;

   typedef struct packed {
      logic       valid;
      tok_id_type id;
   } retire_type;

endpackage

// ===== hw/rtl/mpc_cell.sv =====
// One storage cell of the row: holds a single entry and forwards the token.
module mpc_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  mpc_pkg::tok_id_type   cell_index,
   input  mpc_pkg::token_type    tok_in,
   input  mpc_pkg::retire_type   retire,
   output mpc_pkg::token_type    tok_out
);

   mpc_pkg::data_type  data_ff, data_in;
   mpc_pkg::prio_type  prio_ff, prio_in;
   logic               live_ff, live_in;
   mpc_pkg::token_type tok_ff, tok_in_next;
   mpc_pkg::prio_type  prio_inc;
   logic               match;

   assign match    = (tok_in.id == cell_index);
   assign prio_inc = (prio_ff == mpc_pkg::PRIO_MAX) ? prio_ff
                                                    : prio_ff + mpc_pkg::prio_type'(1);

   always_comb begin
      data_in     = data_ff;
      prio_in     = prio_ff;
      live_in     = live_ff;
      tok_in_next = tok_in;
      if (tok_in.valid) begin
         case (tok_in.cmd)
            mpc_pkg::CMD_ADD: begin
               if (match) begin
                  data_in = tok_in.data;
                  prio_in = '0;
                  live_in = 1'b1;
               end
            end
            mpc_pkg::CMD_PROMOTE: begin
               if (match && live_ff) begin
                  prio_in          = prio_inc;
                  tok_in_next.prio = prio_inc;
                  tok_in_next.flag = 1'b1;
               end
            end
            mpc_pkg::CMD_GET_MAX, mpc_pkg::CMD_POP_MAX: begin
               // >= while walking up the ids hands ties to the larger id
               if (live_ff && (!tok_in.flag || prio_ff >= tok_in.prio)) begin
                  tok_in_next.id   = cell_index;
                  tok_in_next.data = data_ff;
                  tok_in_next.prio = prio_ff;
                  tok_in_next.flag = 1'b1;
               end
            end
            mpc_pkg::CMD_IS_VALID: begin
               if (match) begin
                  tok_in_next.flag = live_ff;
               end
            end
            mpc_pkg::CMD_GET: begin
               if (match && live_ff) begin
                  tok_in_next.data = data_ff;
                  tok_in_next.prio = prio_ff;
                  tok_in_next.flag = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      if (retire.valid && retire.id == cell_index) begin
         live_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      prio_ff <= prio_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= 1'b0;
         tok_ff  <= '0;
      end else begin
         live_ff <= live_in;
         tok_ff  <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ===== hw/rtl/max_priority_collection_unit.sv =====
// Top level of the max priority collection unit: command sequencer and cell row.
//
// Commands arrive on the req_ channel (tuser carries the command code, tdata
// the entry id and the data word); every accepted command gives exactly one
// transfer on the rsp_ channel (tuser carries the status, tdata the id, data,
// priority and live mark).
// Each command sends a token down a row of CAPACITY cells, one cell per
// cycle; each cell holds one entry and updates the token (max search, lookup,
// write). A command passes from the launch register through every cell
// register into the finish register and then into the output register. One
// command is in work at a time, so a new command is taken only once the last
// response is loaded. An add to a full store skips the row and goes straight
// to the finish register. Pop max retires the chosen entry in the cycle its
// response is loaded.
// req_tready is high only while no command is in work. The response sits in
// an output register; a new command may be taken while it waits. If rsp_tready
// stays low, the next finished command holds in the sequencer until the
// output register frees.
// Reset clears all live marks and the id counter at once; no clearing pass.
module max_priority_collection_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // entry_id[7:0], data_in[39:8]
   input  logic [2:0]  req_tuser,   // command[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // result_id[7:0], result_data[39:8],
                                    // result_priority[55:40], is_live[56], zero
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   mpc_pkg::state_type  state_ff, state_in;
   mpc_pkg::cnt_type    next_id_ff, next_id_in;
   mpc_pkg::token_type  launch_ff, launch_in;
   mpc_pkg::token_type  fin_ff, fin_in;
   logic                full_ff, full_in;
   mpc_pkg::retire_type retire;
   mpc_pkg::token_type  chain [mpc_pkg::CAPACITY+1];

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [7:0]          rsp_id_ff, rsp_id_in;
   logic [31:0]         rsp_data_ff, rsp_data_in;
   logic [15:0]         rsp_prio_ff, rsp_prio_in;
   logic                rsp_live_ff, rsp_live_in;

   mpc_pkg::cmd_type    req_cmd;
   logic                accept, load, store_full;
   mpc_pkg::status_type res_status;
   logic [7:0]          res_id;
   logic [31:0]         res_data;
   logic [15:0]         res_prio;
   logic                res_live;

   assign req_cmd    = mpc_pkg::cmd_type'(req_tuser);
   assign req_tready = (state_ff == mpc_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign store_full = (next_id_ff == mpc_pkg::CAPACITY_CNT);
   assign load       = (state_ff == mpc_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   // Response fields from the finished token
   always_comb begin
      res_status = mpc_pkg::STATUS_OK;
      res_id     = '0;
      res_data   = '0;
      res_prio   = '0;
      res_live   = 1'b0;
      case (fin_ff.cmd)
         mpc_pkg::CMD_ADD: begin
            if (full_ff) begin
               res_status = mpc_pkg::STATUS_FULL;
            end else begin
               res_id   = 8'(fin_ff.id);
               res_live = 1'b1;
            end
         end
         mpc_pkg::CMD_PROMOTE: begin
            res_id = 8'(fin_ff.id);
            if (fin_ff.flag) begin
               res_prio = 16'(fin_ff.prio);
               res_live = 1'b1;
            end else begin
               res_status = mpc_pkg::STATUS_BAD;
            end
         end
         mpc_pkg::CMD_GET_MAX, mpc_pkg::CMD_POP_MAX: begin
            if (fin_ff.flag) begin
               res_id   = 8'(fin_ff.id);
               res_data = 32'(fin_ff.data);
               res_prio = 16'(fin_ff.prio);
               res_live = (fin_ff.cmd == mpc_pkg::CMD_GET_MAX);
            end else begin
               res_status = mpc_pkg::STATUS_EMPTY;
            end
         end
         mpc_pkg::CMD_IS_VALID: begin
            res_id   = 8'(fin_ff.id);
            res_live = fin_ff.flag;
         end
         mpc_pkg::CMD_GET: begin
            res_id = 8'(fin_ff.id);
            if (fin_ff.flag) begin
               res_data = 32'(fin_ff.data);
               res_prio = 16'(fin_ff.prio);
               res_live = 1'b1;
            end else begin
               res_status = mpc_pkg::STATUS_BAD;
            end
         end
         default: begin
         end
      endcase
   end

   // Sequencer: next state and control
   always_comb begin
      state_in        = state_ff;
      next_id_in      = next_id_ff;
      launch_in       = launch_ff;
      launch_in.valid = 1'b0;
      fin_in          = fin_ff;
      full_in         = full_ff;
      retire          = '0;
      case (state_ff)
         mpc_pkg::ST_IDLE: begin
            if (accept) begin
               full_in = 1'b0;
               launch_in.cmd  = req_cmd;
               launch_in.id   = mpc_pkg::tok_id_type'(req_tdata[7:0]);
               launch_in.data = '0;
               launch_in.prio = '0;
               launch_in.flag = 1'b0;
               if (req_cmd == mpc_pkg::CMD_ADD) begin
                  launch_in.id   = mpc_pkg::tok_id_type'(next_id_ff);
                  launch_in.data = mpc_pkg::data_type'(req_tdata[39:8]);
               end
               if (req_cmd == mpc_pkg::CMD_GET_MAX || req_cmd == mpc_pkg::CMD_POP_MAX) begin
                  launch_in.id = '0;
               end
               if (req_cmd == mpc_pkg::CMD_ADD && store_full) begin
                  full_in  = 1'b1;
                  fin_in   = launch_in;
                  state_in = mpc_pkg::ST_FINISH;
               end else begin
                  launch_in.valid = 1'b1;
                  state_in        = mpc_pkg::ST_SCAN;
                  if (req_cmd == mpc_pkg::CMD_ADD) begin
                     next_id_in = next_id_ff + mpc_pkg::cnt_type'(1);
                  end
               end
            end
         end
         mpc_pkg::ST_SCAN: begin
            if (chain[mpc_pkg::CAPACITY].valid) begin
               fin_in   = chain[mpc_pkg::CAPACITY];
               state_in = mpc_pkg::ST_FINISH;
            end
         end
         mpc_pkg::ST_FINISH: begin
            if (load) begin
               state_in = mpc_pkg::ST_IDLE;
               if (fin_ff.cmd == mpc_pkg::CMD_POP_MAX && fin_ff.flag) begin
                  retire.valid = 1'b1;
                  retire.id    = fin_ff.id;
               end
            end
         end
         default: begin
            state_in = mpc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_live_in   = rsp_live_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status;
         rsp_id_in     = res_id;
         rsp_data_in   = res_data;
         rsp_prio_in   = res_prio;
         rsp_live_in   = res_live;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpc_pkg::ST_IDLE;
         next_id_ff   <= '0;
         launch_ff    <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_id_ff   <= next_id_in;
         launch_ff    <= launch_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff        <= fin_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_live_ff   <= rsp_live_in;
   end

   assign chain[0] = launch_ff;

   for (genvar i = 0; i < mpc_pkg::CAPACITY; i++) begin : g_cell
      mpc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (mpc_pkg::tok_id_type'(i)),
         .tok_in     (chain[i]),
         .retire     (retire),
         .tok_out    (chain[i+1])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'b0, rsp_live_ff, rsp_prio_ff, rsp_data_ff, rsp_id_ff};

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the max priority collection unit.
module testbench;
   import mpc_pkg::*;

   // Codes outside the command set; the block must answer them with all zeros.
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   localparam int RANDOM_ITEMS   = 830;
   localparam int QUIET_ITEMS    = 120;
   localparam int HOLD_CYCLES    = 1500;
   localparam int DRAIN_CYCLES   = CAPACITY + 16;
   localparam int WATCHDOG_LIMIT = 4 * (HOLD_CYCLES + CAPACITY + 16);

   typedef struct packed {
      status_type         status;
      logic [ID_BITS-1:0] id;
      data_type           data;
      prio_type           prio;
      logic               live;
   } result_type;

   class collection_scoreboard;
      data_type    word_mem[CAPACITY];
      prio_type    prio_mem[CAPACITY];
      bit          live_mem[CAPACITY];
      int unsigned next_id;
      int unsigned live_count;
      result_type  pending_results[$];
      int unsigned mismatch_count;

      function new();
         foreach (live_mem[i]) begin
            live_mem[i] = 1'b0;
            word_mem[i] = '0;
            prio_mem[i] = '0;
         end
         next_id        = 0;
         live_count     = 0;
         mismatch_count = 0;
      endfunction

      function bit holds(logic [ID_BITS-1:0] id);
         return (int'(id) < CAPACITY) && live_mem[id];
      endfunction

      // Highest priority wins; ties go to the larger id.
      function int unsigned top_entry();
         int unsigned best;
         best = 0;
         for (int unsigned i = 0; i < CAPACITY; i++)
            if (live_mem[i] && (!live_mem[best] || prio_mem[i] >= prio_mem[best]))
               best = i;
         return best;
      endfunction

      function void note_command(logic [2:0] code, logic [ID_BITS-1:0] id, data_type word);
         result_type r;
         int unsigned m;
         r = '0;
         case (code)
            CMD_ADD: begin
               if (next_id >= CAPACITY) begin
                  r.status = STATUS_FULL;
               end else begin
                  word_mem[next_id] = word;
                  prio_mem[next_id] = '0;
                  live_mem[next_id] = 1'b1;
                  r.id   = ID_BITS'(next_id);
                  r.live = 1'b1;
                  next_id++;
                  live_count++;
               end
            end
            CMD_PROMOTE: begin
               r.id = id;
               if (!holds(id)) begin
                  r.status = STATUS_BAD;
               end else begin
                  if (prio_mem[id] != PRIO_MAX)
                     prio_mem[id] = prio_mem[id] + 1'b1;
                  r.prio = prio_mem[id];
                  r.live = 1'b1;
               end
            end
            CMD_GET_MAX, CMD_POP_MAX: begin
               if (live_count == 0) begin
                  r.status = STATUS_EMPTY;
               end else begin
                  m      = top_entry();
                  r.id   = ID_BITS'(m);
                  r.data = word_mem[m];
                  r.prio = prio_mem[m];
                  r.live = 1'b1;
                  if (code == CMD_POP_MAX) begin
                     live_mem[m] = 1'b0;
                     live_count--;
                     r.live = 1'b0;
                  end
               end
            end
            CMD_IS_VALID: begin
               r.id   = id;
               r.live = holds(id);
            end
            CMD_GET: begin
               r.id = id;
               if (!holds(id)) begin
                  r.status = STATUS_BAD;
               end else begin
                  r.data = word_mem[id];
                  r.prio = prio_mem[id];
                  r.live = 1'b1;
               end
            end
            default: ;
         endcase
         pending_results.push_back(r);
      endfunction

      task report(string msg);
         if (mismatch_count < 40)
            $display("MISMATCH at %0t: %s", $realtime, msg);
         mismatch_count++;
      endtask

      task check_result(logic [1:0] st, logic [63:0] td);
         result_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("response with no command waiting, tdata %h", td));
            return;
         end
         want = pending_results.pop_front();
         if (st !== want.status)
            report($sformatf("status %0d, expected %0d", st, want.status));
         if (td[7:0] !== want.id)
            report($sformatf("result_id %0d, expected %0d", td[7:0], want.id));
         if (td[39:8] !== want.data)
            report($sformatf("result_data %h, expected %h", td[39:8], want.data));
         if (td[55:40] !== want.prio)
            report($sformatf("result_priority %0d, expected %0d", td[55:40], want.prio));
         if (td[56] !== want.live)
            report($sformatf("is_live %b, expected %b", td[56], want.live));
         if (td[63:57] !== 7'd0)
            report($sformatf("pad bits %b, expected zero", td[63:57]));
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   collection_scoreboard board = new();

   bit          quiet         = 1'b0;
   bit          hold_request  = 1'b0;
   int unsigned send_idle_pct = 0;

   max_priority_collection_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   task automatic send_command(logic [2:0] code, logic [ID_BITS-1:0] id, data_type word);
      if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         // sometimes line the gap up with the block coming free
         if ($urandom_range(0, 1) == 1)
            do @(posedge clock); while (!req_tready);
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= code;
      req_tdata  <= {word, id};
      do @(posedge clock); while (!req_tready);
      board.note_command(code, id, word);
   endtask

   // Mostly ids already handed out, weighted toward the newest few.
   function automatic logic [ID_BITS-1:0] pick_id();
      int unsigned issued;
      issued = board.next_id;
      if (issued == 0 || $urandom_range(0, 99) < 25)
         return ID_BITS'($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 1)
         return ID_BITS'($urandom_range(issued > 6 ? issued - 6 : 0, issued - 1));
      return ID_BITS'($urandom_range(0, issued - 1));
   endfunction

   function automatic data_type pick_word();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0)
         return '0;
      if (roll == 1)
         return '1;
      return $urandom;
   endfunction

   initial begin : receiver
      int unsigned stall_left;
      int unsigned recv_idle_pct;
      int unsigned cycle_count;
      stall_left    = 0;
      recv_idle_pct = 10;
      cycle_count   = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            board.check_result(rsp_tuser, rsp_tdata);
         cycle_count++;
         if (cycle_count % 3000 == 0)
            recv_idle_pct = $urandom_range(0, 2) * 10;
         if (quiet)
            recv_idle_pct = 0;
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (hold_request) begin
            // long hold-off: block fills its output and stalls the request side
            hold_request = 1'b0;
            stall_left   = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < recv_idle_pct) begin
            stall_left = $urandom_range(0, 6);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("max_priority_collection_unit regression: fail");
      $finish;
   end

   initial begin : stimulus
      int unsigned roll;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty store, never-assigned ids
      send_command(CMD_GET_MAX,  8'd0,   '0);
      send_command(CMD_POP_MAX,  8'd0,   '0);
      send_command(CMD_GET,      8'd0,   '0);
      send_command(CMD_PROMOTE,  8'd255, '1);
      send_command(CMD_IS_VALID, 8'd0,   '0);
      // data extremes, zero-priority tie goes to the larger id
      send_command(CMD_ADD,      8'd255, 32'h0000_0000);
      send_command(CMD_ADD,      8'd0,   32'hFFFF_FFFF);
      send_command(CMD_ADD,      8'd170, 32'hA5A5_5A5A);
      send_command(CMD_GET_MAX,  8'd0,   '0);
      send_command(CMD_PROMOTE,  8'd0,   '0);
      send_command(CMD_PROMOTE,  8'd0,   '0);
      send_command(CMD_PROMOTE,  8'd1,   '0);
      send_command(CMD_GET_MAX,  8'd0,   '0);
      send_command(CMD_GET,      8'd1,   '0);
      send_command(CMD_IS_VALID, 8'd1,   '0);
      // retire, then the retired id is refused and not revived
      send_command(CMD_POP_MAX,  8'd0,   '0);
      send_command(CMD_GET,      8'd0,   '0);
      send_command(CMD_PROMOTE,  8'd0,   '0);
      send_command(CMD_IS_VALID, 8'd0,   '0);
      send_command(CMD_SPARE_6,  8'd255, '1);
      send_command(CMD_SPARE_7,  8'd85,  32'h5555_AAAA);
      send_command(CMD_IS_VALID, 8'd255, '0);
      send_command(CMD_POP_MAX,  8'd0,   '0);
      send_command(CMD_POP_MAX,  8'd0,   '0);
      send_command(CMD_GET_MAX,  8'd0,   '0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0)
            send_idle_pct = $urandom_range(0, 3) * 10;
         if (n == 300)
            hold_request = 1'b1;
         if (n == RANDOM_ITEMS - QUIET_ITEMS)
            quiet = 1'b1;
         roll = $urandom_range(0, 99);
         if (roll < 34)
            send_command(CMD_ADD, ID_BITS'($urandom), pick_word());
         else if (roll < 62)
            send_command(CMD_PROMOTE, pick_id(), pick_word());
         else if (roll < 70)
            send_command(CMD_GET_MAX, ID_BITS'($urandom), pick_word());
         else if (roll < 78)
            send_command(CMD_POP_MAX, ID_BITS'($urandom), pick_word());
         else if (roll < 86)
            send_command(CMD_IS_VALID, pick_id(), pick_word());
         else if (roll < 95)
            send_command(CMD_GET, pick_id(), pick_word());
         else
            send_command(roll[0] ? CMD_SPARE_7 : CMD_SPARE_6, pick_id(), pick_word());
      end
      req_tvalid <= 1'b0;

      while (board.pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.mismatch_count == 0 && board.pending_results.size() == 0)
         $display("max_priority_collection_unit regression: pass");
      else
         $display("max_priority_collection_unit regression: fail");
      $finish;
   end

endmodule
